FILE: rtl/sjq_pkg.sv
// ----------------------------------------------------------------------------
// sjq_pkg: shared definitions of the shortest-job ordered queue
// Sizes, entry and result types, operation and status codes, sequencer
// states and the circular-buffer address helper.
// ----------------------------------------------------------------------------
package sjq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned ID_BITS     = 16;
  localparam int unsigned LENGTH_BITS = 16;
  localparam int unsigned ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  count_t;

  // one queued job
  typedef struct packed {
    logic [ID_BITS-1:0]     id;
    logic [LENGTH_BITS-1:0] len;
  } entry_t;

  // operation codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_POP    = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // one result item
  typedef struct packed {
    logic                   popped_valid;
    logic [ID_BITS-1:0]     popped_id;
    logic [LENGTH_BITS-1:0] popped_length;
    count_t                 occupancy;
    status_e                status;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN,
    ST_TAIL,
    ST_DONE
  } state_e;

  // physical slot of logical position k, counted from the head
  function automatic addr_t phys_addr(addr_t head, count_t k);
    logic [ADDR_W:0] sum;
    sum = {1'b0, head} + {1'b0, k[ADDR_W-1:0]};
    if (sum >= (ADDR_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (ADDR_W + 1)'(QUEUE_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

FILE: rtl/sjq_in_if.sv
// ----------------------------------------------------------------------------
// sjq_in_if: operation channel
// Valid/ready channel carrying one queue operation per item.
// ----------------------------------------------------------------------------
interface sjq_in_if import sjq_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic [1:0]             mode;
  logic [ID_BITS-1:0]     job_id;
  logic [LENGTH_BITS-1:0] job_length;

  modport source (output valid, output mode, output job_id, output job_length, input ready);
  modport sink   (input valid, input mode, input job_id, input job_length, output ready);

endinterface

FILE: rtl/sjq_out_if.sv
// ----------------------------------------------------------------------------
// sjq_out_if: result channel
// Valid/ready channel carrying one result item per operation.
// ----------------------------------------------------------------------------
interface sjq_out_if import sjq_pkg::*; ();

  logic                   valid;
  logic                   ready;
  logic                   popped_valid;
  logic [ID_BITS-1:0]     popped_id;
  logic [LENGTH_BITS-1:0] popped_length;
  logic [CNT_W-1:0]       occupancy;
  logic [1:0]             status;

  modport source (
    output valid, output popped_valid, output popped_id, output popped_length,
    output occupancy, output status, input ready
  );
  modport sink (
    input valid, input popped_valid, input popped_id, input popped_length,
    input occupancy, input status, output ready
  );

endinterface

FILE: rtl/sjq_ram.sv
// ----------------------------------------------------------------------------
// sjq_ram: simple dual-port memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sjq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/shortest_job_ordered_queue_unit.sv
// ----------------------------------------------------------------------------
// shortest_job_ordered_queue_unit: bounded job queue with ordered insert
// Circular buffer in one memory; an ordered insert walks the entries from
// the head with one read and one write a cycle, shifting later jobs up.
// ----------------------------------------------------------------------------
// result for append, dropped push, empty pop and no-op passes ST_DONE into the output register;
// a pop passes ST_POP first, an ordered insert into n jobs ST_SCAN over them and then ST_TAIL
// one item at a time: a new item is taken only back in ST_IDLE, once ST_DONE has handed the
// result to a free output register; an insert walks over the single memory read port
// reset: count, head and sequencer cleared, queue empty; memory not cleared
module shortest_job_ordered_queue_unit import sjq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  sjq_in_if.sink   item_i,
  sjq_out_if.source result_o
);

  state_e  state_q, state_d;
  addr_t   head_q, head_d;
  count_t  count_q, count_d;
  count_t  proc_q, proc_d;
  logic    found_q, found_d;
  entry_t  carry_q, carry_d;
  entry_t  new_q, new_d;
  result_t res_q, res_d;
  logic    outv_q, outv_d;
  result_t out_q, out_d;

  logic   ram_we;
  addr_t  ram_waddr;
  entry_t ram_wdata;
  addr_t  ram_raddr;
  entry_t ram_rdata;

  logic   accept;
  logic   out_free;
  logic   full;
  logic   empty;
  logic   scan_last;
  entry_t in_entry;
  count_t count_inc;
  count_t count_dec;

  assign item_i.ready = (state_q == ST_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign out_free     = !outv_q || result_o.ready;
  assign full         = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty        = (count_q == '0);
  assign scan_last    = (proc_q == count_dec);
  assign count_inc    = count_q + CNT_W'(1);
  assign count_dec    = count_q - CNT_W'(1);
  assign in_entry     = '{id: item_i.job_id, len: item_i.job_length};

  // queue storage
  sjq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH ($bits(entry_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_e'(item_i.mode))
            MODE_INSERT: state_d = (full || empty) ? ST_DONE : ST_SCAN;
            MODE_POP:    state_d = empty ? ST_DONE : ST_POP;
            default:     state_d = ST_DONE;
          endcase
        end
      end
      ST_POP:  state_d = ST_DONE;
      ST_SCAN: state_d = scan_last ? ST_TAIL : ST_SCAN;
      ST_TAIL: state_d = ST_DONE;
      ST_DONE: state_d = out_free ? ST_IDLE : ST_DONE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    proc_d    = proc_q;
    found_d   = found_q;
    carry_d   = carry_q;
    new_d     = new_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = phys_addr(head_q, count_q);
    ram_wdata = new_q;
    ram_raddr = head_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d = '{popped_valid: 1'b0, popped_id: '0, popped_length: '0,
                    occupancy: count_q, status: STATUS_OK};
          case (mode_e'(item_i.mode))
            MODE_APPEND, MODE_INSERT: begin
              if (full) begin
                res_d.status = STATUS_FULL;
              end else if (item_i.mode == MODE_APPEND || empty) begin
                // straight to the tail
                ram_we          = 1'b1;
                ram_wdata       = in_entry;
                count_d         = count_inc;
                res_d.occupancy = count_inc;
              end else begin
                // start the walk at the head
                new_d   = in_entry;
                proc_d  = '0;
                found_d = 1'b0;
              end
            end
            MODE_POP: begin
              if (empty) begin
                res_d.status = STATUS_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end

      // head entry has arrived from the memory
      ST_POP: begin
        res_d.popped_valid  = 1'b1;
        res_d.popped_id     = ram_rdata.id;
        res_d.popped_length = ram_rdata.len;
        res_d.occupancy     = count_dec;
        head_d              = phys_addr(head_q, CNT_W'(1));
        count_d             = count_dec;
      end

      // data of position proc_q is here; fetch the next one
      ST_SCAN: begin
        ram_raddr = phys_addr(head_q, proc_q + CNT_W'(1));
        ram_waddr = phys_addr(head_q, proc_q);
        if (found_q) begin
          ram_we    = 1'b1;
          ram_wdata = carry_q;
          carry_d   = ram_rdata;
        end else if (ram_rdata.len > new_q.len) begin
          ram_we    = 1'b1;
          ram_wdata = new_q;
          carry_d   = ram_rdata;
          found_d   = 1'b1;
        end
        if (!scan_last) begin
          proc_d = proc_q + CNT_W'(1);
        end
      end

      // last job moves to the new tail slot, or the new job goes there
      ST_TAIL: begin
        ram_we          = 1'b1;
        ram_wdata       = found_q ? carry_q : new_q;
        count_d         = count_inc;
        res_d.occupancy = count_inc;
      end

      default: ;
    endcase
  end

  // output register
  always_comb begin
    outv_d = outv_q;
    out_d  = out_q;
    if (result_o.ready) begin
      outv_d = 1'b0;
    end
    if (state_q == ST_DONE && out_free) begin
      outv_d = 1'b1;
      out_d  = res_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      found_q <= 1'b0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      found_q <= found_d;
      outv_q  <= outv_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    proc_q  <= proc_d;
    carry_q <= carry_d;
    new_q   <= new_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign result_o.valid         = outv_q;
  assign result_o.popped_valid  = out_q.popped_valid;
  assign result_o.popped_id     = out_q.popped_id;
  assign result_o.popped_length = out_q.popped_length;
  assign result_o.occupancy     = out_q.occupancy;
  assign result_o.status        = out_q.status;

  // occupancy never exceeds the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // the walk stays inside the queued jobs
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> proc_q < count_q)
    else $error("walk index beyond tail");

  // every accepted item leaves the idle state
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("accepted item produced no work");

  // a dropped push reports a full queue
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.status == STATUS_FULL
      |-> result_o.occupancy == CNT_W'(QUEUE_DEPTH) && !result_o.popped_valid)
    else $error("drop flagged without full queue");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the shortest-job ordered queue
// A directed table of operations (extremes, full and empty queue, equal
// lengths, no-op) is followed by biased random fill and drain traffic under
// four idling phases. Every result item is checked against a queue model or a table entry.
// ----------------------------------------------------------------------------
module testbench import sjq_pkg::*; ();

  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef logic [ID_BITS-1:0]     id_t;
  typedef logic [LENGTH_BITS-1:0] len_t;

  // one row of the directed table
  typedef struct {
    mode_e   mode;
    id_t     id;
    len_t    len;
    bit      fixed;
    result_t res;
  } op_row_t;

  logic clk;
  logic rst_n;

  sjq_in_if  op_if ();
  sjq_out_if res_if ();

  shortest_job_ordered_queue_unit i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (op_if),
    .result_o(res_if)
  );

  entry_t      job_model[$];
  result_t     expected_results[$];
  int unsigned errors         = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // clock, 10 ns period, first rising edge after reset is driven
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic result_t make_result(bit v, id_t id, len_t len, count_t occ,
                                          status_e st);
    result_t r;
    r.popped_valid  = v;
    r.popped_id     = id;
    r.popped_length = len;
    r.occupancy     = occ;
    r.status        = st;
    return r;
  endfunction

  // queue model: apply one operation, return the result it yields
  function automatic result_t apply_job_op(mode_e m, id_t id, len_t len);
    entry_t e;
    int     pos;
    bit     v;
    id_t    pid;
    len_t   plen;
    status_e st;
    v    = 1'b0;
    pid  = '0;
    plen = '0;
    st   = STATUS_OK;
    e.id  = id;
    e.len = len;
    case (m)
      MODE_APPEND, MODE_INSERT: begin
        if (job_model.size() >= QUEUE_DEPTH) begin
          st = STATUS_FULL;
        end else begin
          pos = job_model.size();
          if (m == MODE_INSERT) begin
            // in front of the first strictly longer job
            for (int k = job_model.size() - 1; k >= 0; k--) begin
              if (job_model[k].len > len) pos = k;
            end
          end
          job_model.insert(pos, e);
        end
      end
      MODE_POP: begin
        if (job_model.size() == 0) begin
          st = STATUS_EMPTY;
        end else begin
          e    = job_model.pop_front();
          v    = 1'b1;
          pid  = e.id;
          plen = e.len;
        end
      end
      default: ;
    endcase
    return make_result(v, pid, plen, count_t'(job_model.size()), st);
  endfunction

  // present one item, hold it until accepted, then record its expectation
  task automatic send_op(mode_e m, id_t id, len_t len, bit fixed, result_t fixed_res);
    result_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      op_if.valid <= 1'b0;
      @(negedge clk);
    end
    op_if.valid      <= 1'b1;
    op_if.mode       <= m;
    op_if.job_id     <= id;
    op_if.job_length <= len;
    @(posedge clk);
    while (!op_if.ready) @(posedge clk);
    predicted = apply_job_op(m, id, len);
    expected_results.push_back(fixed ? fixed_res : predicted);
  endtask

  // receiver back-pressure, changed at the falling edge
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result item with no expectation waiting");
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (res_if.popped_valid !== want.popped_valid) begin
          $error("popped_valid: expected %0d, actual %0d", want.popped_valid,
                 res_if.popped_valid);
          errors++;
        end
        if (res_if.popped_id !== want.popped_id) begin
          $error("popped_id: expected %0h, actual %0h", want.popped_id, res_if.popped_id);
          errors++;
        end
        if (res_if.popped_length !== want.popped_length) begin
          $error("popped_length: expected %0h, actual %0h", want.popped_length,
                 res_if.popped_length);
          errors++;
        end
        if (res_if.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", want.occupancy, res_if.occupancy);
          errors++;
        end
        if (res_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, res_if.status);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus
  initial begin
    op_row_t directed_ops[$];
    result_t none;
    mode_e   m;
    id_t     id;
    len_t    len;
    bit      filling;
    int unsigned r;

    none             = make_result(1'b0, '0, '0, '0, STATUS_OK);
    op_if.valid      = 1'b0;
    op_if.mode       = MODE_APPEND;
    op_if.job_id     = '0;
    op_if.job_length = '0;
    rst_n            = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    directed_ops = '{
      // empty queue after reset, no-op, extremes
      '{MODE_POP,    16'h0000, 16'h0000, 1'b1,
        make_result(1'b0, '0, '0, count_t'(0), STATUS_EMPTY)},
      '{MODE_NOP,    16'hffff, 16'hffff, 1'b1,
        make_result(1'b0, '0, '0, count_t'(0), STATUS_OK)},
      '{MODE_APPEND, 16'hffff, 16'hffff, 1'b1,
        make_result(1'b0, '0, '0, count_t'(1), STATUS_OK)},
      '{MODE_INSERT, 16'h0000, 16'h0000, 1'b1,
        make_result(1'b0, '0, '0, count_t'(2), STATUS_OK)},
      '{MODE_POP,    16'h0000, 16'h0000, 1'b1,
        make_result(1'b1, '0, '0, count_t'(1), STATUS_OK)},
      '{MODE_POP,    16'h1234, 16'h5678, 1'b1,
        make_result(1'b1, 16'hffff, 16'hffff, count_t'(0), STATUS_OK)},
      '{MODE_POP,    16'h0000, 16'h0000, 1'b1,
        make_result(1'b0, '0, '0, count_t'(0), STATUS_EMPTY)},
      // equal lengths, insert at head and at tail
      '{MODE_INSERT, 16'h0001, 16'h0005, 1'b1,
        make_result(1'b0, '0, '0, count_t'(1), STATUS_OK)},
      '{MODE_INSERT, 16'h0002, 16'h0005, 1'b0, none},
      '{MODE_INSERT, 16'h0003, 16'h0003, 1'b0, none},
      '{MODE_INSERT, 16'h0004, 16'hffff, 1'b0, none},
      '{MODE_APPEND, 16'h0005, 16'h0000, 1'b0, none},
      '{MODE_INSERT, 16'h0006, 16'h0005, 1'b0, none},
      // fill to the brim
      '{MODE_INSERT, 16'haaaa, 16'haaaa, 1'b0, none},
      '{MODE_APPEND, 16'h5555, 16'h5555, 1'b0, none},
      '{MODE_INSERT, 16'h8000, 16'h8000, 1'b0, none},
      '{MODE_INSERT, 16'h7fff, 16'h7fff, 1'b0, none},
      '{MODE_INSERT, 16'h0007, 16'hffff, 1'b0, none},
      '{MODE_INSERT, 16'h0008, 16'h0000, 1'b0, none},
      '{MODE_APPEND, 16'h0009, 16'h0001, 1'b0, none},
      '{MODE_INSERT, 16'h000a, 16'h0004, 1'b0, none},
      '{MODE_INSERT, 16'h000b, 16'h0005, 1'b0, none},
      '{MODE_INSERT, 16'h000c, 16'h0002, 1'b0, none},
      // push into a full queue
      '{MODE_APPEND, 16'hffff, 16'h0000, 1'b1,
        make_result(1'b0, '0, '0, count_t'(16), STATUS_FULL)},
      '{MODE_INSERT, 16'h0000, 16'h0000, 1'b1,
        make_result(1'b0, '0, '0, count_t'(16), STATUS_FULL)},
      '{MODE_POP,    16'h0000, 16'h0000, 1'b0, none}
    };

    foreach (directed_ops[i]) begin
      send_op(directed_ops[i].mode, directed_ops[i].id, directed_ops[i].len,
              directed_ops[i].fixed, directed_ops[i].res);
    end

    // random fill and drain traffic under four idling phases
    filling = 1'b0;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      case (n * 4 / RANDOM_ITEMS)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      if (job_model.size() == QUEUE_DEPTH && $urandom_range(3) == 0) filling = 1'b0;
      if (job_model.size() == 0 && $urandom_range(3) == 0) filling = 1'b1;
      if ($urandom_range(29) == 0) filling = !filling;

      r = $urandom_range(99);
      if (r < 4) begin
        m = MODE_NOP;
      end else if ((filling && r < 79) || (!filling && r < 29)) begin
        m = ($urandom_range(99) < 65) ? MODE_INSERT : MODE_APPEND;
      end else begin
        m = MODE_POP;
      end

      // mostly short lengths so that ties happen often
      r = $urandom_range(9);
      if (r < 6)       len = len_t'($urandom_range(7));
      else if (r == 6) len = '0;
      else if (r == 7) len = '1;
      else             len = len_t'($urandom());
      id = id_t'($urandom());

      send_op(m, id, len, 1'b0, none);
    end

    @(negedge clk);
    op_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
